// File: src/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

	// width of a run length and of the totals reported on the result
	localparam int CNT_W = 11;

	// request kinds
	typedef enum logic [2:0] {
		K_CLEAR,
		K_ADD_BEGIN,
		K_ADD_WORD,
		K_FINISH,
		K_FIND,
		K_READ_INDEX,
		K_READ_WORD,
		K_CHECKSUM
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        item_type;
		logic [15:0]        item_id;
		logic [CNT_W-1:0]   word_count;
		logic [5:0]         entry_index;
		logic [9:0]         word_pos;
		logic signed [31:0] word_in;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [15:0]        found_type;
		logic [15:0]        found_id;
		logic [5:0]         found_index;
		logic [CNT_W-1:0]   found_count;
		logic [CNT_W-1:0]   total_words;
		logic signed [31:0] word_out;
		logic [31:0]        sum_out;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_SORT_LD,
		ST_SORT_HOLD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_IDX_RD,
		ST_WD_ENT,
		ST_WD_WORD,
		ST_SUM_KEY,
		ST_SUM_WORD,
		ST_SUM_DRAIN,
		ST_SUM_OUT
	} state_t;

endpackage

`default_nettype wire

// File: src/krt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module krt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/keyed_record_table_core.sv
// Keyed record table: records keyed by {item_type, item_id}, each holding a run of
// 32-bit words. Entries (key, offset, length) live in one synchronous memory and the
// words in another; all searching and sorting is done by a sequencer that reads one
// entry per step, so one request is handled at a time. Clear, add word and requests
// rejected on arrival are answered straight from idle. Add begin scans the stored keys
// in turn. Finish runs an insertion sort through the entry memory. Find runs a binary
// search, read by index reads one entry, read word an entry and then a word, and
// checksum adds up every stored key and word. The result sits in an output register;
// a new request is taken only once it is collected, at the earliest in the cycle it is
// collected.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table_core
	import krt_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int MAX_WORDS   = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_stall,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = $clog2(MAX_WORDS);
	localparam int TW = $clog2(MAX_WORDS + 1);
	localparam int RW = 32 + TW + CNT_W;

	state_t state_q, state_nx;

	logic [NW-1:0]    entry_total_q;
	logic [TW-1:0]    word_total_q;
	logic             sealed_q;
	logic [TW-1:0]    wptr_q;
	logic [CNT_W-1:0] pend_q;
	logic             rsp_valid_q;
	logic             kv_s1, wv_s1;

	req_t             req_q;
	rsp_t             rsp_q;
	logic [NW-1:0]    idx_q, j_q, lo_q, hi_q, mid_q;
	logic [TW-1:0]    widx_q;
	logic [RW-1:0]    hold_q;
	logic [31:0]      sum_q;

	logic             ent_we;
	logic [EW-1:0]    ent_waddr, ent_raddr;
	logic [RW-1:0]    ent_wdata, ent_rdata;
	logic             wrd_we;
	logic [AW-1:0]    wrd_waddr, wrd_raddr;
	logic [31:0]      wrd_wdata, wrd_rdata;

	logic             req_fire;
	logic             rsp_load;
	rsp_t             rsp_d;

	logic [31:0]      rd_key, key_q, key_in, hold_key;
	logic [TW-1:0]    rd_off;
	logic [CNT_W-1:0] rd_len;
	logic             add_rej, add_hit, ent_last, ent_full, do_append, do_rewrite;
	logic             sort_gt, sort_last, do_seal_now, idx_bad, wd_bad;
	logic [31:0]      wd_addr;
	logic [NW-1:0]    mid;

	// memories
	krt_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);

	krt_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_wrd_ram (
		.clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
		.raddr(wrd_raddr), .rdata(wrd_rdata)
	);

	// handshake
	assign req_fire  = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// shared decode of entry data and conditions
	always_comb begin
		rd_key      = ent_rdata[RW-1 -: 32];
		rd_off      = ent_rdata[CNT_W +: TW];
		rd_len      = ent_rdata[CNT_W-1:0];
		key_q       = {req_q.item_type, req_q.item_id};
		key_in      = {req.item_type, req.item_id};
		hold_key    = hold_q[RW-1 -: 32];
		add_rej     = sealed_q || (pend_q != '0) ||
			((32'(word_total_q) + 32'(req.word_count)) > 32'(MAX_WORDS));
		add_hit     = (rd_key == key_q);
		ent_last    = (32'(idx_q) + 32'd1) == 32'(entry_total_q);
		ent_full    = 32'(entry_total_q) >= 32'(MAX_ENTRIES);
		do_append   = (state_q == ST_IDLE && req_fire && req.kind == K_ADD_BEGIN &&
			!add_rej && entry_total_q == '0) ||
			(state_q == ST_ADD_CMP && !add_hit && ent_last && !ent_full);
		do_rewrite  = (state_q == ST_ADD_CMP) && add_hit && (rd_len == req_q.word_count);
		sort_gt     = rd_key > hold_key;
		sort_last   = ent_last;
		do_seal_now = !sealed_q && (pend_q == '0) && (32'(entry_total_q) <= 32'd1);
		idx_bad     = !sealed_q || (32'(req.entry_index) >= 32'(entry_total_q));
		wd_addr     = 32'(rd_off) + 32'(req_q.word_pos);
		wd_bad      = (32'(req_q.word_pos) >= 32'(rd_len)) || (wd_addr >= 32'(MAX_WORDS));
		mid         = NW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					unique case (req.kind)
						K_ADD_BEGIN: if (!add_rej && entry_total_q != '0) state_nx = ST_ADD_RD;
						K_FINISH: if (!sealed_q && pend_q == '0 && !do_seal_now)
							state_nx = ST_SORT_LD;
						K_FIND: if (sealed_q) state_nx = ST_FIND_RD;
						K_READ_INDEX: if (!idx_bad) state_nx = ST_IDX_RD;
						K_READ_WORD: if (!idx_bad) state_nx = ST_WD_ENT;
						K_CHECKSUM: if (pend_q == '0) state_nx = ST_SUM_KEY;
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: state_nx = ST_ADD_CMP;
			ST_ADD_CMP: state_nx = (add_hit || ent_last) ? ST_IDLE : ST_ADD_RD;
			ST_SORT_LD: state_nx = ST_SORT_HOLD;
			ST_SORT_HOLD: state_nx = ST_SORT_RD;
			ST_SORT_CMP: begin
				if (sort_gt) begin
					state_nx = (j_q == NW'(1)) ? ST_SORT_PUT : ST_SORT_RD;
				end else begin
					state_nx = sort_last ? ST_IDLE : ST_SORT_LD;
				end
			end
			ST_SORT_RD: state_nx = ST_SORT_CMP;
			ST_SORT_PUT: state_nx = sort_last ? ST_IDLE : ST_SORT_LD;
			ST_FIND_RD: state_nx = (lo_q >= hi_q) ? ST_IDLE : ST_FIND_CMP;
			ST_FIND_CMP: state_nx = (rd_key == key_q) ? ST_IDLE : ST_FIND_RD;
			ST_IDX_RD: state_nx = ST_IDLE;
			ST_WD_ENT: state_nx = wd_bad ? ST_IDLE : ST_WD_WORD;
			ST_WD_WORD: state_nx = ST_IDLE;
			ST_SUM_KEY: if (32'(idx_q) >= 32'(entry_total_q)) state_nx = ST_SUM_WORD;
			ST_SUM_WORD: if (widx_q >= word_total_q) state_nx = ST_SUM_DRAIN;
			ST_SUM_DRAIN: state_nx = ST_SUM_OUT;
			ST_SUM_OUT: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// memory controls and result
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = '0;
		ent_raddr = '0;
		wrd_we    = 1'b0;
		wrd_waddr = wptr_q[AW-1:0];
		wrd_wdata = req.word_in;
		wrd_raddr = '0;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		if (do_append) begin
			ent_we    = 1'b1;
			ent_waddr = entry_total_q[EW-1:0];
			ent_wdata = (state_q == ST_IDLE) ?
				{key_in, word_total_q, req.word_count} :
				{key_q, word_total_q, req_q.word_count};
			rsp_load  = 1'b1;
			rsp_d.ok  = 1'b1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					unique case (req.kind)
						K_CLEAR: begin
							rsp_load = 1'b1;
							rsp_d.ok = 1'b1;
						end
						K_ADD_BEGIN: if (add_rej) rsp_load = 1'b1;
						K_ADD_WORD: begin
							rsp_load = 1'b1;
							if (pend_q != '0) begin
								wrd_we   = 1'b1;
								rsp_d.ok = 1'b1;
							end
						end
						K_FINISH: begin
							rsp_d.total_words = CNT_W'(word_total_q);
							if (sealed_q || pend_q != '0 || do_seal_now) begin
								rsp_load = 1'b1;
								rsp_d.ok = sealed_q || do_seal_now;
							end
						end
						K_FIND: if (!sealed_q) rsp_load = 1'b1;
						K_READ_INDEX, K_READ_WORD: begin
							ent_raddr = EW'(req.entry_index);
							if (idx_bad) rsp_load = 1'b1;
						end
						K_CHECKSUM: if (pend_q != '0) rsp_load = 1'b1;
						default: rsp_load = 1'b0;
					endcase
				end
			end
			ST_ADD_RD: ent_raddr = idx_q[EW-1:0];
			ST_ADD_CMP: begin
				if (add_hit) begin
					rsp_load = 1'b1;
					rsp_d.ok = do_rewrite;
				end else if (ent_last && ent_full) begin
					rsp_load = 1'b1;
				end
			end
			ST_SORT_LD: ent_raddr = idx_q[EW-1:0];
			ST_SORT_HOLD: ent_raddr = idx_q[EW-1:0];
			ST_SORT_RD: ent_raddr = EW'(j_q - 1'b1);
			ST_SORT_CMP: begin
				ent_we    = 1'b1;
				ent_waddr = j_q[EW-1:0];
				ent_wdata = sort_gt ? ent_rdata : hold_q;
				if (!sort_gt && sort_last) begin
					rsp_load          = 1'b1;
					rsp_d.ok          = 1'b1;
					rsp_d.total_words = CNT_W'(word_total_q);
				end
			end
			ST_SORT_PUT: begin
				ent_we    = 1'b1;
				ent_waddr = '0;
				ent_wdata = hold_q;
				if (sort_last) begin
					rsp_load          = 1'b1;
					rsp_d.ok          = 1'b1;
					rsp_d.total_words = CNT_W'(word_total_q);
				end
			end
			ST_FIND_RD: begin
				ent_raddr = mid[EW-1:0];
				if (lo_q >= hi_q) rsp_load = 1'b1;
			end
			ST_FIND_CMP: begin
				if (rd_key == key_q) begin
					rsp_load          = 1'b1;
					rsp_d.ok          = 1'b1;
					rsp_d.found_type  = rd_key[31:16];
					rsp_d.found_id    = rd_key[15:0];
					rsp_d.found_index = 6'(mid_q);
					rsp_d.found_count = rd_len;
				end
			end
			ST_IDX_RD: begin
				rsp_load          = 1'b1;
				rsp_d.ok          = 1'b1;
				rsp_d.found_type  = rd_key[31:16];
				rsp_d.found_id    = rd_key[15:0];
				rsp_d.found_index = req_q.entry_index;
				rsp_d.found_count = rd_len;
			end
			ST_WD_ENT: begin
				wrd_raddr = AW'(wd_addr);
				if (wd_bad) rsp_load = 1'b1;
			end
			ST_WD_WORD: begin
				rsp_load       = 1'b1;
				rsp_d.ok       = 1'b1;
				rsp_d.word_out = wrd_rdata;
			end
			ST_SUM_KEY: ent_raddr = idx_q[EW-1:0];
			ST_SUM_WORD: wrd_raddr = widx_q[AW-1:0];
			ST_SUM_DRAIN: rsp_load = 1'b0;
			ST_SUM_OUT: begin
				rsp_load      = 1'b1;
				rsp_d.ok      = 1'b1;
				rsp_d.sum_out = sum_q;
			end
			default: rsp_load = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_total_q <= '0;
			word_total_q  <= '0;
			sealed_q      <= 1'b0;
			wptr_q        <= '0;
			pend_q        <= '0;
			rsp_valid_q   <= 1'b0;
			kv_s1         <= 1'b0;
			wv_s1         <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			kv_s1 <= (state_q == ST_SUM_KEY) && (32'(idx_q) < 32'(entry_total_q));
			wv_s1 <= (state_q == ST_SUM_WORD) && (widx_q < word_total_q);
			if (state_q == ST_IDLE && req_fire && req.kind == K_CLEAR) begin
				entry_total_q <= '0;
				word_total_q  <= '0;
				sealed_q      <= 1'b0;
				wptr_q        <= '0;
				pend_q        <= '0;
			end
			if (state_q == ST_IDLE && req_fire && req.kind == K_ADD_WORD && pend_q != '0) begin
				wptr_q <= wptr_q + 1'b1;
				pend_q <= pend_q - 1'b1;
			end
			if (do_append) begin
				wptr_q        <= word_total_q;
				entry_total_q <= entry_total_q + 1'b1;
				if (state_q == ST_IDLE) begin
					word_total_q <= TW'(32'(word_total_q) + 32'(req.word_count));
					pend_q       <= req.word_count;
				end else begin
					word_total_q <= TW'(32'(word_total_q) + 32'(req_q.word_count));
					pend_q       <= req_q.word_count;
				end
			end
			if (do_rewrite) begin
				wptr_q <= rd_off;
				pend_q <= req_q.word_count;
			end
			if ((state_q == ST_IDLE && req_fire && req.kind == K_FINISH && do_seal_now) ||
				(state_q == ST_SORT_CMP && !sort_gt && sort_last) ||
				(state_q == ST_SORT_PUT && sort_last)) begin
				sealed_q <= 1'b1;
			end
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					req_q  <= req;
					idx_q  <= (req.kind == K_FINISH) ? NW'(1) : '0;
					widx_q <= '0;
					sum_q  <= '0;
					lo_q   <= '0;
					hi_q   <= entry_total_q;
				end
			end
			ST_ADD_CMP: idx_q <= idx_q + 1'b1;
			ST_SORT_HOLD: begin
				hold_q <= ent_rdata;
				j_q    <= idx_q;
			end
			ST_SORT_CMP: begin
				if (sort_gt) begin
					j_q <= j_q - 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_SORT_PUT: idx_q <= idx_q + 1'b1;
			ST_FIND_RD: mid_q <= mid;
			ST_FIND_CMP: begin
				if (rd_key < key_q) begin
					lo_q <= mid_q + 1'b1;
				end else if (rd_key > key_q) begin
					hi_q <= mid_q;
				end
			end
			ST_SUM_KEY: if (32'(idx_q) < 32'(entry_total_q)) idx_q <= idx_q + 1'b1;
			ST_SUM_WORD: if (widx_q < word_total_q) widx_q <= widx_q + 1'b1;
			default: mid_q <= mid_q;
		endcase
		// checksum accumulation from the previous cycle's reads
		if (state_q != ST_IDLE) begin
			sum_q <= sum_q + (kv_s1 ? rd_key : 32'd0) + (wv_s1 ? wrd_rdata : 32'd0);
		end
	end

`ifndef SYNTH
	a_pend_unsealed: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != '0 |-> !sealed_q)
		else $error("words pending while table sealed");

	a_wptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(wptr_q) + 32'(pend_q)) <= 32'(word_total_q))
		else $error("pending run runs past stored words");

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(entry_total_q) <= 32'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result written over an uncollected one");
`endif

endmodule

`default_nettype wire
